FILE: src/pcsm_pkg.sv
// Shared constants for the p-code stack machine execute unit.
// No dependencies; used by the top level and the divider.
package pcsm_pkg;

    localparam int WORD_BITS   = 32;
    localparam int STACK_DEPTH = 4096;
    localparam int ADDR_BITS   = 12;
    localparam int TOP_BITS    = 13;
    localparam int PC_BITS     = 11;
    localparam int LEV_BITS    = 2;
    localparam int OP_BITS     = 3;
    localparam int FLT_BITS    = 2;

    // operations
    localparam logic [OP_BITS-1:0] OP_LIT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_OPR = 3'd1;
    localparam logic [OP_BITS-1:0] OP_LOD = 3'd2;
    localparam logic [OP_BITS-1:0] OP_STO = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CAL = 3'd4;
    localparam logic [OP_BITS-1:0] OP_INT = 3'd5;
    localparam logic [OP_BITS-1:0] OP_JMP = 3'd6;
    localparam logic [OP_BITS-1:0] OP_JPC = 3'd7;

    // OPR sub-codes
    localparam logic [PC_BITS-1:0] OPR_RET = 11'd0;
    localparam logic [PC_BITS-1:0] OPR_NEG = 11'd1;
    localparam logic [PC_BITS-1:0] OPR_ADD = 11'd2;
    localparam logic [PC_BITS-1:0] OPR_SUB = 11'd3;
    localparam logic [PC_BITS-1:0] OPR_MUL = 11'd4;
    localparam logic [PC_BITS-1:0] OPR_DIV = 11'd5;
    localparam logic [PC_BITS-1:0] OPR_ODD = 11'd6;
    localparam logic [PC_BITS-1:0] OPR_EQ  = 11'd8;
    localparam logic [PC_BITS-1:0] OPR_NE  = 11'd9;
    localparam logic [PC_BITS-1:0] OPR_LT  = 11'd10;
    localparam logic [PC_BITS-1:0] OPR_GE  = 11'd11;
    localparam logic [PC_BITS-1:0] OPR_GT  = 11'd12;
    localparam logic [PC_BITS-1:0] OPR_LE  = 11'd13;

    // fault codes
    localparam logic [FLT_BITS-1:0] FLT_NONE = 2'd0;
    localparam logic [FLT_BITS-1:0] FLT_DIV  = 2'd1;
    localparam logic [FLT_BITS-1:0] FLT_ACC  = 2'd2;

endpackage

FILE: src/pcode_stack_machine_execute_unit.sv
// Execute core of the PL/0 p-code stack machine.
// Depends on pcsm_pkg and pcsm_div.
//
// Input channel (i_in_valid / o_in_ready) carries one fetched instruction:
// operation, level and argument. Output channel (o_out_valid / i_out_ready)
// returns one result per instruction: next program counter, top word, top
// index, frame base, halt flag and fault code.
// The data stack lives in one 4096 x 32 synchronous RAM, one read and one
// write per cycle. Each instruction is a short read-modify-write sequence:
// INT, JMP and LIT go from EXEC straight to FIN; JPC and OPR read their
// operands in RA and RB, divide waits in DIV, and LOD/STO/CAL first walk
// the static links in WALK/WALKW. The RAM port and the divider shape this path.
// One instruction is in flight at a time; a new one is accepted while the
// previous result waits at the output register.
// After reset the RAM is cleared one word per cycle, with o_in_ready low
// until it is done. Registers reset to top = -1, base = 0, pc = 0.
// When the receiver stalls, the finished result holds in the output
// register and the core waits with the next result until it is taken.
module pcode_stack_machine_execute_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [pcsm_pkg::OP_BITS-1:0]         i_operation,
    input  logic [pcsm_pkg::LEV_BITS-1:0]        i_level,
    input  logic [pcsm_pkg::PC_BITS-1:0]         i_argument,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pcsm_pkg::PC_BITS-1:0]         o_next_pc,
    output logic signed [pcsm_pkg::WORD_BITS-1:0] o_top_value,
    output logic signed [pcsm_pkg::TOP_BITS-1:0] o_top_index,
    output logic [pcsm_pkg::ADDR_BITS-1:0]       o_frame_base,
    output logic                                 o_halted,
    output logic [pcsm_pkg::FLT_BITS-1:0]        o_fault
);
    localparam int W  = pcsm_pkg::WORD_BITS;
    localparam int AW = pcsm_pkg::ADDR_BITS;
    localparam int TW = pcsm_pkg::TOP_BITS;
    localparam int PW = pcsm_pkg::PC_BITS;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_EXEC  = 10'b0000000100,
        S_WALK  = 10'b0000001000,
        S_WALKW = 10'b0000010000,
        S_RA    = 10'b0000100000,
        S_RB    = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [W-1:0] r_mem [pcsm_pkg::STACK_DEPTH];
    logic [W-1:0] r_rdata;

    logic [TW-1:0] r_top, n_top;
    logic [AW-1:0] r_base, n_base;
    logic [PW-1:0] r_pc, n_pc;
    logic [pcsm_pkg::OP_BITS-1:0]  r_op, n_op;
    logic [pcsm_pkg::LEV_BITS-1:0] r_hops, n_hops;
    logic [PW-1:0] r_arg, n_arg;
    logic [W-1:0]  r_w, n_w;
    logic [W-1:0]  r_a, n_a;
    logic          r_acc, n_acc;
    logic          r_dz, n_dz;
    logic          r_rd_ok, n_rd_ok;
    logic [AW-1:0] r_clr, n_clr;

    logic          r_ovalid, n_ovalid;
    logic [PW-1:0] r_opc;
    logic [W-1:0]  r_oval;
    logic [TW-1:0] r_otop;
    logic [AW-1:0] r_obase;
    logic [pcsm_pkg::FLT_BITS-1:0] r_oflt;
    logic          load_out;

    logic          rd_req, rd_ok, wr_req, wr_ok, mem_we, mem_re;
    logic [AW-1:0] rd_addr, wr_addr, mem_wa;
    logic [W-1:0]  wr_data, mem_wd, rd_data, alu;
    logic [TW-1:0] top_inc, top_dec;
    logic [TW:0]   tp1, tp2, tp3;
    logic [AW:0]   bp1, bp2;
    logic [W:0]    wi;
    logic          wi_ok, w0_ok, is_arith;
    logic          div_start, div_done;
    logic [W-1:0]  div_q;

    pcsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (rd_data),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign rd_data = r_rd_ok ? r_rdata : '0;
    assign top_inc = r_top + TW'(1);
    assign top_dec = r_top - TW'(1);
    assign tp1     = {r_top[TW-1], r_top} + (TW+1)'(1);
    assign tp2     = {r_top[TW-1], r_top} + (TW+1)'(2);
    assign tp3     = {r_top[TW-1], r_top} + (TW+1)'(3);
    assign bp1     = {1'b0, r_base} + (AW+1)'(1);
    assign bp2     = {1'b0, r_base} + (AW+1)'(2);
    assign wi      = {1'b0, r_w} + (W+1)'(r_arg);
    assign wi_ok   = !r_w[W-1] && (wi < (W+1)'(pcsm_pkg::STACK_DEPTH));
    assign w0_ok   = (r_w[W-1:AW] == '0);
    assign is_arith = ((r_arg >= pcsm_pkg::OPR_ADD) && (r_arg <= pcsm_pkg::OPR_DIV))
                   || ((r_arg >= pcsm_pkg::OPR_EQ) && (r_arg <= pcsm_pkg::OPR_LE));

    // binary operators on a = r_a (lower word), b = rd_data (upper word)
    always_comb begin
        case (r_arg)
            pcsm_pkg::OPR_ADD: alu = r_a + rd_data;
            pcsm_pkg::OPR_SUB: alu = r_a - rd_data;
            pcsm_pkg::OPR_MUL: alu = r_a * rd_data;
            pcsm_pkg::OPR_EQ:  alu = W'(r_a == rd_data);
            pcsm_pkg::OPR_NE:  alu = W'(r_a != rd_data);
            pcsm_pkg::OPR_LT:  alu = W'($signed(r_a) < $signed(rd_data));
            pcsm_pkg::OPR_GE:  alu = W'(!($signed(r_a) < $signed(rd_data)));
            pcsm_pkg::OPR_GT:  alu = W'($signed(rd_data) < $signed(r_a));
            pcsm_pkg::OPR_LE:  alu = W'(!($signed(rd_data) < $signed(r_a)));
            default:           alu = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_top    = r_top;
        n_base   = r_base;
        n_pc     = r_pc;
        n_op     = r_op;
        n_hops   = r_hops;
        n_arg    = r_arg;
        n_w      = r_w;
        n_a      = r_a;
        n_dz     = r_dz;
        n_rd_ok  = r_rd_ok;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && !i_out_ready;
        rd_req   = 1'b0;
        rd_ok    = 1'b0;
        rd_addr  = '0;
        wr_req   = 1'b0;
        wr_ok    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        div_start = 1'b0;
        load_out = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_hops  = i_level;
                    n_arg   = i_argument;
                    n_pc    = r_pc + PW'(1);
                    n_dz    = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                n_w     = {{(W-AW){1'b0}}, r_base};
                case (r_op)
                    pcsm_pkg::OP_LIT: begin
                        n_top   = top_inc;
                        wr_req  = 1'b1;
                        wr_ok   = !top_inc[TW-1];
                        wr_addr = top_inc[AW-1:0];
                        wr_data = W'(r_arg);
                    end
                    pcsm_pkg::OP_INT: n_top = r_top + TW'(r_arg);
                    pcsm_pkg::OP_JMP: n_pc  = r_arg;
                    pcsm_pkg::OP_JPC: begin
                        rd_req  = 1'b1;
                        rd_ok   = !r_top[TW-1];
                        rd_addr = r_top[AW-1:0];
                        n_state = S_RA;
                    end
                    pcsm_pkg::OP_OPR: begin
                        if (r_arg == pcsm_pkg::OPR_RET) begin
                            rd_req  = 1'b1;
                            rd_ok   = !bp2[AW];
                            rd_addr = bp2[AW-1:0];
                            n_state = S_RA;
                        end else if (r_arg == pcsm_pkg::OPR_NEG
                                     || r_arg == pcsm_pkg::OPR_ODD) begin
                            rd_req  = 1'b1;
                            rd_ok   = !r_top[TW-1];
                            rd_addr = r_top[AW-1:0];
                            n_state = S_RA;
                        end else if (is_arith) begin
                            n_top   = top_dec;
                            rd_req  = 1'b1;
                            rd_ok   = !top_dec[TW-1];
                            rd_addr = top_dec[AW-1:0];
                            n_state = S_RA;
                        end
                    end
                    default: begin
                        // LOD, STO, CAL: walk static links first
                        if (r_op == pcsm_pkg::OP_LOD) n_top = top_inc;
                        n_state = S_WALK;
                    end
                endcase
            end
            S_WALK: begin
                if (r_hops != '0) begin
                    rd_req  = 1'b1;
                    rd_ok   = w0_ok;
                    rd_addr = r_w[AW-1:0];
                    n_state = S_WALKW;
                end else begin
                    n_state = S_RA;
                    case (r_op)
                        pcsm_pkg::OP_LOD: begin
                            rd_req  = 1'b1;
                            rd_ok   = wi_ok;
                            rd_addr = wi[AW-1:0];
                        end
                        pcsm_pkg::OP_STO: begin
                            rd_req  = 1'b1;
                            rd_ok   = !r_top[TW-1];
                            rd_addr = r_top[AW-1:0];
                        end
                        default: begin
                            wr_req  = 1'b1;
                            wr_ok   = (tp1[TW:AW] == '0);
                            wr_addr = tp1[AW-1:0];
                            wr_data = r_w;
                        end
                    endcase
                end
            end
            S_WALKW: begin
                n_w     = rd_data;
                n_hops  = r_hops - pcsm_pkg::LEV_BITS'(1);
                n_state = S_WALK;
            end
            S_RA: begin
                n_state = S_FIN;
                n_a     = rd_data;
                case (r_op)
                    pcsm_pkg::OP_JPC: begin
                        if (rd_data == W'(1)) n_pc = r_arg;
                        n_top = top_dec;
                    end
                    pcsm_pkg::OP_LOD: begin
                        wr_req  = 1'b1;
                        wr_ok   = !r_top[TW-1];
                        wr_addr = r_top[AW-1:0];
                        wr_data = rd_data;
                    end
                    pcsm_pkg::OP_STO: begin
                        wr_req  = 1'b1;
                        wr_ok   = wi_ok;
                        wr_addr = wi[AW-1:0];
                        wr_data = rd_data;
                        n_top   = top_dec;
                    end
                    pcsm_pkg::OP_CAL: begin
                        wr_req  = 1'b1;
                        wr_ok   = (tp2[TW:AW] == '0);
                        wr_addr = tp2[AW-1:0];
                        wr_data = W'(r_base);
                        n_state = S_RB;
                    end
                    default: begin
                        // OPR
                        if (r_arg == pcsm_pkg::OPR_RET) begin
                            rd_req  = 1'b1;
                            rd_ok   = !bp1[AW];
                            rd_addr = bp1[AW-1:0];
                            n_state = S_RB;
                        end else if (r_arg == pcsm_pkg::OPR_NEG
                                     || r_arg == pcsm_pkg::OPR_ODD) begin
                            wr_req  = 1'b1;
                            wr_ok   = !r_top[TW-1];
                            wr_addr = r_top[AW-1:0];
                            wr_data = (r_arg == pcsm_pkg::OPR_NEG) ? (W'(0) - rd_data)
                                                                   : W'(rd_data[0]);
                        end else begin
                            rd_req  = 1'b1;
                            rd_ok   = (tp1[TW:AW] == '0);
                            rd_addr = tp1[AW-1:0];
                            n_state = S_RB;
                        end
                    end
                endcase
            end
            S_RB: begin
                n_state = S_FIN;
                if (r_op == pcsm_pkg::OP_CAL) begin
                    wr_req  = 1'b1;
                    wr_ok   = (tp3[TW:AW] == '0);
                    wr_addr = tp3[AW-1:0];
                    wr_data = W'(r_pc);
                    n_base  = tp1[AW-1:0];
                    n_pc    = r_arg;
                end else if (r_arg == pcsm_pkg::OPR_RET) begin
                    n_pc   = r_a[PW-1:0];
                    n_base = rd_data[AW-1:0];
                    n_top  = {1'b0, r_base} - TW'(1);
                end else if (r_arg == pcsm_pkg::OPR_DIV && rd_data != '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    if (r_arg == pcsm_pkg::OPR_DIV) n_dz = 1'b1;
                    wr_req  = 1'b1;
                    wr_ok   = !r_top[TW-1];
                    wr_addr = r_top[AW-1:0];
                    wr_data = alu;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    wr_req  = 1'b1;
                    wr_ok   = !r_top[TW-1];
                    wr_addr = r_top[AW-1:0];
                    wr_data = div_q;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // fetch the new top word for the result; never a fault
                rd_req  = 1'b1;
                rd_ok   = !r_top[TW-1];
                rd_addr = r_top[AW-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (rd_req) n_rd_ok = rd_ok;
        n_acc = (r_state == S_IDLE) ? 1'b0
              : (r_acc || (rd_req && !rd_ok && r_state != S_FIN) || (wr_req && !wr_ok));
    end

    assign mem_re = rd_req && rd_ok;
    assign mem_we = (r_state == S_CLEAR) || (wr_req && wr_ok);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : wr_addr;
    assign mem_wd = (r_state == S_CLEAR) ? '0 : wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_top    <= '1;
            r_base   <= '0;
            r_pc     <= '0;
            r_acc    <= 1'b0;
            r_dz     <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_top    <= n_top;
            r_base   <= n_base;
            r_pc     <= n_pc;
            r_acc    <= n_acc;
            r_dz     <= n_dz;
            r_rd_ok  <= n_rd_ok;
            r_ovalid <= n_ovalid;
        end
        r_op   <= n_op;
        r_hops <= n_hops;
        r_arg  <= n_arg;
        r_w    <= n_w;
        r_a    <= n_a;
        if (load_out) begin
            r_opc   <= r_pc;
            r_oval  <= rd_data;
            r_otop  <= r_top;
            r_obase <= r_base;
            r_oflt  <= r_acc ? pcsm_pkg::FLT_ACC
                     : (r_dz ? pcsm_pkg::FLT_DIV : pcsm_pkg::FLT_NONE);
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_next_pc    = r_opc;
    assign o_top_value  = r_oval;
    assign o_top_index  = r_otop;
    assign o_frame_base = r_obase;
    assign o_halted     = (r_opc == '0);
    assign o_fault      = r_oflt;

endmodule

FILE: src/pcsm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on pcsm_pkg for the word width.
module pcsm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcsm_pkg::WORD_BITS-1:0] i_dividend,
    input  logic [pcsm_pkg::WORD_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [pcsm_pkg::WORD_BITS-1:0] o_quotient
);
    localparam int W  = pcsm_pkg::WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_sh = {r_rem[W-1:0], r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            n_dvs  = i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            n_neg  = i_dividend[W-1] ^ i_divisor[W-1];
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[W]) begin
                n_rem = diff;
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for pcode_stack_machine_execute_unit.
// Depends on pcsm_pkg and the execute unit RTL. It holds its own model of the
// stack machine, sends directed and random instruction streams, and checks every result.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [pcsm_pkg::PC_BITS-1:0]   pc;
        logic [pcsm_pkg::WORD_BITS-1:0] tv;
        logic [pcsm_pkg::TOP_BITS-1:0]  ti;
        logic [pcsm_pkg::ADDR_BITS-1:0] fb;
        logic                           halt;
        logic [pcsm_pkg::FLT_BITS-1:0]  flt;
    } t_exec_result;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic out_ready;
    logic [pcsm_pkg::OP_BITS-1:0]  in_op;
    logic [pcsm_pkg::LEV_BITS-1:0] in_lev;
    logic [pcsm_pkg::PC_BITS-1:0]  in_arg;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [pcsm_pkg::PC_BITS-1:0]  o_next_pc;
    logic signed [pcsm_pkg::WORD_BITS-1:0] o_top_value;
    logic signed [pcsm_pkg::TOP_BITS-1:0]  o_top_index;
    logic [pcsm_pkg::ADDR_BITS-1:0] o_frame_base;
    logic                           o_halted;
    logic [pcsm_pkg::FLT_BITS-1:0]  o_fault;

    pcode_stack_machine_execute_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (in_op),
        .i_level      (in_lev),
        .i_argument   (in_arg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_next_pc    (o_next_pc),
        .o_top_value  (o_top_value),
        .o_top_index  (o_top_index),
        .o_frame_base (o_frame_base),
        .o_halted     (o_halted),
        .o_fault      (o_fault)
    );

    // machine model state
    logic [pcsm_pkg::WORD_BITS-1:0] mdl_mem [pcsm_pkg::STACK_DEPTH];
    logic [pcsm_pkg::TOP_BITS-1:0]  mdl_top;
    logic [pcsm_pkg::ADDR_BITS-1:0] mdl_base;
    logic [pcsm_pkg::PC_BITS-1:0]   mdl_pc;
    bit                             mdl_acc_flt;

    t_exec_result expected_q [$];
    int  err_cnt;
    int  sent_cnt;
    int  burst_left;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("FAIL pcode_stack_machine_execute_unit");
        $finish;
    end

    function automatic longint top_s();
        return longint'($signed(mdl_top));
    endfunction

    function automatic logic [pcsm_pkg::WORD_BITS-1:0] mem_rd(longint i);
        if (i < 0 || i >= pcsm_pkg::STACK_DEPTH) begin
            mdl_acc_flt = 1'b1;
            return '0;
        end
        return mdl_mem[i];
    endfunction

    function automatic void mem_wr(longint i, logic [pcsm_pkg::WORD_BITS-1:0] w);
        if (i < 0 || i >= pcsm_pkg::STACK_DEPTH) begin
            mdl_acc_flt = 1'b1;
            return;
        end
        mdl_mem[i] = w;
    endfunction

    // word used as an index; negative or too large maps to -1
    function automatic longint word_idx(logic [pcsm_pkg::WORD_BITS-1:0] w, longint off);
        longint a;
        if (w[pcsm_pkg::WORD_BITS-1]) return -1;
        a = longint'(w) + off;
        if (a >= pcsm_pkg::STACK_DEPTH) return -1;
        return a;
    endfunction

    function automatic logic [pcsm_pkg::WORD_BITS-1:0] frame_walk(
        logic [pcsm_pkg::LEV_BITS-1:0] lev);
        logic [pcsm_pkg::WORD_BITS-1:0] w;
        w = pcsm_pkg::WORD_BITS'(mdl_base);
        for (int n = 0; n < lev; n++) w = mem_rd(word_idx(w, 0));
        return w;
    endfunction

    function automatic logic [pcsm_pkg::WORD_BITS-1:0] sdiv(
        logic [pcsm_pkg::WORD_BITS-1:0] a, logic [pcsm_pkg::WORD_BITS-1:0] b);
        longint unsigned ma, mb, q;
        ma = a[pcsm_pkg::WORD_BITS-1] ? longint'(-a) : longint'(a);
        mb = b[pcsm_pkg::WORD_BITS-1] ? longint'(-b) : longint'(b);
        ma = ma & 64'hFFFF_FFFF;
        mb = mb & 64'hFFFF_FFFF;
        q  = ma / mb;
        return (a[pcsm_pkg::WORD_BITS-1] != b[pcsm_pkg::WORD_BITS-1])
               ? pcsm_pkg::WORD_BITS'(-q) : pcsm_pkg::WORD_BITS'(q);
    endfunction

    task automatic exec_model(logic [pcsm_pkg::OP_BITS-1:0] op,
                              logic [pcsm_pkg::LEV_BITS-1:0] lev,
                              logic [pcsm_pkg::PC_BITS-1:0] arg);
        logic [pcsm_pkg::WORD_BITS-1:0] a, b, r, fr;
        longint t, nb;
        bit dz;
        t_exec_result res;
        dz = 1'b0;
        mdl_acc_flt = 1'b0;
        mdl_pc = mdl_pc + 1'b1;
        case (op)
            pcsm_pkg::OP_LIT: begin
                mdl_top = mdl_top + 1'b1;
                mem_wr(top_s(), pcsm_pkg::WORD_BITS'(arg));
            end
            pcsm_pkg::OP_OPR: begin
                t = top_s();
                if (arg == pcsm_pkg::OPR_RET) begin
                    nb = longint'(mdl_base);
                    mdl_top  = pcsm_pkg::TOP_BITS'(mdl_base) - 1'b1;
                    mdl_pc   = pcsm_pkg::PC_BITS'(mem_rd(nb + 2));
                    mdl_base = pcsm_pkg::ADDR_BITS'(mem_rd(nb + 1));
                end else if (arg == pcsm_pkg::OPR_NEG) begin
                    mem_wr(t, -mem_rd(t));
                end else if (arg == pcsm_pkg::OPR_ODD) begin
                    mem_wr(t, mem_rd(t) & 32'd1);
                end else if ((arg >= pcsm_pkg::OPR_ADD && arg <= pcsm_pkg::OPR_DIV) ||
                             (arg >= pcsm_pkg::OPR_EQ && arg <= pcsm_pkg::OPR_LE)) begin
                    mdl_top = mdl_top - 1'b1;
                    t = top_s();
                    a = mem_rd(t);
                    b = mem_rd(t + 1);
                    case (arg)
                        pcsm_pkg::OPR_ADD: r = a + b;
                        pcsm_pkg::OPR_SUB: r = a - b;
                        pcsm_pkg::OPR_MUL: r = a * b;
                        pcsm_pkg::OPR_DIV: begin
                            if (b == 0) begin
                                dz = 1'b1;
                                r  = '0;
                            end else r = sdiv(a, b);
                        end
                        pcsm_pkg::OPR_EQ: r = pcsm_pkg::WORD_BITS'(a == b);
                        pcsm_pkg::OPR_NE: r = pcsm_pkg::WORD_BITS'(a != b);
                        pcsm_pkg::OPR_LT: r = pcsm_pkg::WORD_BITS'($signed(a) < $signed(b));
                        pcsm_pkg::OPR_GE:
                            r = pcsm_pkg::WORD_BITS'(!($signed(a) < $signed(b)));
                        pcsm_pkg::OPR_GT: r = pcsm_pkg::WORD_BITS'($signed(b) < $signed(a));
                        default: r = pcsm_pkg::WORD_BITS'(!($signed(b) < $signed(a)));
                    endcase
                    mem_wr(t, r);
                end
            end
            pcsm_pkg::OP_LOD: begin
                mdl_top = mdl_top + 1'b1;
                fr = frame_walk(lev);
                r  = mem_rd(word_idx(fr, longint'(arg)));
                mem_wr(top_s(), r);
            end
            pcsm_pkg::OP_STO: begin
                fr = frame_walk(lev);
                mem_wr(word_idx(fr, longint'(arg)), mem_rd(top_s()));
                mdl_top = mdl_top - 1'b1;
            end
            pcsm_pkg::OP_CAL: begin
                t  = top_s();
                fr = frame_walk(lev);
                mem_wr(t + 1, fr);
                mem_wr(t + 2, pcsm_pkg::WORD_BITS'(mdl_base));
                mem_wr(t + 3, pcsm_pkg::WORD_BITS'(mdl_pc));
                mdl_base = pcsm_pkg::ADDR_BITS'(t + 1);
                mdl_pc   = arg;
            end
            pcsm_pkg::OP_INT: mdl_top = mdl_top + pcsm_pkg::TOP_BITS'(arg);
            pcsm_pkg::OP_JMP: mdl_pc = arg;
            default: begin
                if (mem_rd(top_s()) == 1) mdl_pc = arg;
                mdl_top = mdl_top - 1'b1;
            end
        endcase
        t = top_s();
        res.pc   = mdl_pc;
        res.tv   = (t >= 0 && t < pcsm_pkg::STACK_DEPTH) ? mdl_mem[t] : '0;
        res.ti   = mdl_top;
        res.fb   = mdl_base;
        res.halt = (mdl_pc == 0);
        res.flt  = mdl_acc_flt ? pcsm_pkg::FLT_ACC
                 : (dz ? pcsm_pkg::FLT_DIV : pcsm_pkg::FLT_NONE);
        expected_q.push_back(res);
    endtask

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_instr(logic [pcsm_pkg::OP_BITS-1:0] op,
                              logic [pcsm_pkg::LEV_BITS-1:0] lev,
                              logic [pcsm_pkg::PC_BITS-1:0] arg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        exec_model(op, lev, arg);
        sent_cnt++;
        in_valid <= 1'b1;
        in_op    <= op;
        in_lev   <= lev;
        in_arg   <= arg;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // pull the stack top back into a small window with INT requests
    task automatic settle_top();
        logic [pcsm_pkg::TOP_BITS-1:0] amt;
        while (top_s() < 0 || top_s() > 200) begin
            amt = pcsm_pkg::TOP_BITS'(4) - mdl_top;
            send_instr(pcsm_pkg::OP_INT, 2'd0,
                       (amt > 2047) ? 11'd2047 : pcsm_pkg::PC_BITS'(amt));
        end
    endtask

    function automatic logic [pcsm_pkg::PC_BITS-1:0] rand_binop();
        logic [pcsm_pkg::PC_BITS-1:0] codes [10] = '{
            pcsm_pkg::OPR_ADD, pcsm_pkg::OPR_SUB, pcsm_pkg::OPR_MUL, pcsm_pkg::OPR_DIV,
            pcsm_pkg::OPR_EQ, pcsm_pkg::OPR_NE, pcsm_pkg::OPR_LT, pcsm_pkg::OPR_GE,
            pcsm_pkg::OPR_GT, pcsm_pkg::OPR_LE};
        return codes[$urandom_range(0, 9)];
    endfunction

    task automatic test_directed();
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_ADD);  // binary op on an empty stack
        send_instr(pcsm_pkg::OP_INT, 2'd0, 11'd6);
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd2047);
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd0);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_DIV);  // divide by zero
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd1024);
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd1024);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_MUL);
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd1024);
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd2);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_MUL);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_MUL);  // most negative word
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd1);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_NEG);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_DIV);  // min / -1 wraps
        send_instr(pcsm_pkg::OP_LIT, 2'd0, 11'd3);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_NEG);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_ODD);  // odd of a negative value
        send_instr(pcsm_pkg::OP_OPR, 2'd0, 11'd7);              // undefined codes
        send_instr(pcsm_pkg::OP_OPR, 2'd0, 11'd2047);
        send_instr(pcsm_pkg::OP_JPC, 2'd0, 11'd100);            // top is 1: jumps
        send_instr(pcsm_pkg::OP_STO, 2'd3, 11'd2047);           // store outside
        send_instr(pcsm_pkg::OP_CAL, 2'd3, 11'd50);
        send_instr(pcsm_pkg::OP_LOD, 2'd3, 11'd1);
        send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_RET);
        send_instr(pcsm_pkg::OP_JMP, 2'd0, 11'd0);              // lands on halt
    endtask

    task automatic random_segment();
        int k;
        settle_top();
        k = $urandom_range(0, 99);
        if (k < 15) begin
            send_instr(pcsm_pkg::OP_BITS'($urandom), pcsm_pkg::LEV_BITS'($urandom),
                       pcsm_pkg::PC_BITS'($urandom));
        end else if (k < 45) begin
            send_instr(pcsm_pkg::OP_LIT, 2'd0, pcsm_pkg::PC_BITS'($urandom));
            send_instr(pcsm_pkg::OP_LIT, 2'd0,
                       ($urandom_range(0, 3) == 0) ? 11'd0 : pcsm_pkg::PC_BITS'($urandom));
            if ($urandom_range(0, 1)) send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_NEG);
            send_instr(pcsm_pkg::OP_OPR, 2'd0, rand_binop());
        end else if (k < 55) begin
            send_instr(pcsm_pkg::OP_LIT, 2'd0, pcsm_pkg::PC_BITS'($urandom));
            send_instr(pcsm_pkg::OP_OPR, 2'd0,
                       $urandom_range(0, 1) ? pcsm_pkg::OPR_NEG : pcsm_pkg::OPR_ODD);
        end else if (k < 75) begin
            send_instr(pcsm_pkg::OP_LOD, pcsm_pkg::LEV_BITS'($urandom),
                       pcsm_pkg::PC_BITS'($urandom_range(0, 15)));
            send_instr(pcsm_pkg::OP_STO, pcsm_pkg::LEV_BITS'($urandom),
                       pcsm_pkg::PC_BITS'($urandom_range(0, 15)));
        end else if (k < 90) begin
            send_instr(pcsm_pkg::OP_CAL, pcsm_pkg::LEV_BITS'($urandom),
                       pcsm_pkg::PC_BITS'($urandom));
            send_instr(pcsm_pkg::OP_INT, 2'd0, pcsm_pkg::PC_BITS'($urandom_range(3, 8)));
            send_instr(pcsm_pkg::OP_LIT, 2'd0, pcsm_pkg::PC_BITS'($urandom));
            send_instr(pcsm_pkg::OP_STO, pcsm_pkg::LEV_BITS'($urandom_range(0, 1)),
                       pcsm_pkg::PC_BITS'($urandom_range(3, 7)));
            send_instr(pcsm_pkg::OP_LOD, pcsm_pkg::LEV_BITS'($urandom),
                       pcsm_pkg::PC_BITS'($urandom_range(0, 7)));
            send_instr(pcsm_pkg::OP_OPR, 2'd0, pcsm_pkg::OPR_RET);
        end else begin
            send_instr(pcsm_pkg::OP_JMP, 2'd0, pcsm_pkg::PC_BITS'($urandom));
            send_instr(pcsm_pkg::OP_LIT, 2'd0, pcsm_pkg::PC_BITS'($urandom_range(0, 2)));
            send_instr(pcsm_pkg::OP_JPC, 2'd0, pcsm_pkg::PC_BITS'($urandom));
        end
    endtask

    task automatic test_random(int upto);
        while (sent_cnt < upto) random_segment();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) random_segment();
    endtask

    task automatic test_pause();
        drain();
        repeat (30) random_segment();
    endtask

    // result receiver: switches among random stall patterns, and stalls fully on a hold request
    initial begin
        int mode, cnt;
        out_ready = 1'b0;
        mode = 0;
        cnt  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (cnt == 0) mode = $urandom_range(0, 3);
                cnt = (cnt + 1) % 64;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cnt[3:0] < 12);
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_exec_result e;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual pc %h",
                         $time, o_next_pc);
                err_cnt++;
            end else begin
                e = expected_q.pop_front();
                check_field("next_pc", 32'(e.pc), 32'(o_next_pc));
                check_field("top_value", e.tv, o_top_value);
                check_field("top_index", 32'(e.ti), 32'(unsigned'(o_top_index)));
                check_field("frame_base", 32'(e.fb), 32'(o_frame_base));
                check_field("halted", 32'(e.halt), 32'(o_halted));
                check_field("fault", 32'(e.flt), 32'(o_fault));
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_op      = pcsm_pkg::OP_LIT;
        in_lev     = '0;
        in_arg     = '0;
        err_cnt    = 0;
        sent_cnt   = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        for (int i = 0; i < pcsm_pkg::STACK_DEPTH; i++) mdl_mem[i] = '0;
        mdl_top  = '1;
        mdl_base = '0;
        mdl_pc   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_pause();
        test_random(1900);
        drain();
        repeat (60) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t %0d results never arrived", $time, expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("PASS pcode_stack_machine_execute_unit");
        end else begin
            $display("FAIL pcode_stack_machine_execute_unit");
        end
        $finish;
    end

endmodule
